[src/swtd_pkg.sv]
package swtd_pkg;

  // field widths fixed by the sensor frame format
  localparam int LEN_W   = 8;
  localparam int IDX_W   = 7;
  localparam int CNT_W   = 6;
  localparam int BITS_W  = 40;
  localparam int TEMP_W  = 17;
  localparam int Q_W     = 12;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // line level and frame constants
  localparam logic [LEN_W-1:0] TIMEOUT_LEN = 8'hFF;
  localparam logic [CNT_W-1:0] FRAME_BITS  = 6'd40;
  localparam logic [IDX_W-1:0] FIRST_DATA_LEVEL = 7'd4;

  // temperature conversion constants
  localparam logic [14:0]       RAW_LIMIT = 15'd1250;
  localparam logic [TEMP_W-1:0] F_OFFSET  = 17'd3200;
  localparam logic [TEMP_W-1:0] C_SCALE   = 17'd10;
  localparam logic [TEMP_W-1:0] F_SCALE   = 17'd18;
  localparam logic [Q_W-1:0]    DEG_SCALE = 12'd10;

  // status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SHORT    = 2'd1;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

  // register indexes (byte address bit 2)
  localparam logic REG_BIT_THRESHOLD   = 1'b0;
  localparam logic REG_UNIT_FAHRENHEIT = 1'b1;

  // register reset values
  localparam logic [LEN_W-1:0] BIT_THRESHOLD_RST = 8'd16;
  localparam logic             UNIT_RST          = 1'b0;

  // finished frame handed from the frame tracker to the converter
  typedef struct packed {
    logic [BITS_W-1:0] bits;
    logic              full;
  } frame_done_t;

endpackage

[src/swtd_if.sv]
interface swtd_level_if;
  logic                       valid;
  logic                       ready;
  logic [swtd_pkg::LEN_W-1:0] level_length;
  logic                       frame_start;

  modport source (output valid, level_length, frame_start, input ready);
  modport sink (input valid, level_length, frame_start, output ready);
endinterface

interface swtd_result_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic signed [swtd_pkg::TEMP_W-1:0] temperature;

  modport source (output valid, status, temperature, input ready);
  modport sink (input valid, status, temperature, output ready);
endinterface

[src/swtd_regs.sv]
module swtd_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swtd_pkg::ADDR_W-1:0] paddr,
  input  logic [swtd_pkg::DATA_W-1:0] pwdata,
  output logic [swtd_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output logic [swtd_pkg::LEN_W-1:0]  bit_threshold,
  output logic                        unit_fahrenheit
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_threshold   <= swtd_pkg::BIT_THRESHOLD_RST;
      unit_fahrenheit <= swtd_pkg::UNIT_RST;
    end else if (wr_en) begin
      case (paddr[2])
        swtd_pkg::REG_BIT_THRESHOLD:   bit_threshold   <= pwdata[swtd_pkg::LEN_W-1:0];
        swtd_pkg::REG_UNIT_FAHRENHEIT: unit_fahrenheit <= pwdata[0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      swtd_pkg::REG_BIT_THRESHOLD:
        prdata = {{(swtd_pkg::DATA_W-swtd_pkg::LEN_W){1'b0}}, bit_threshold};
      swtd_pkg::REG_UNIT_FAHRENHEIT:
        prdata = {{(swtd_pkg::DATA_W-1){1'b0}}, unit_fahrenheit};
      default:
        prdata = '0;
    endcase
  end

endmodule

[src/swtd_frame.sv]
module swtd_frame #(
  parameter int MAX_LEVELS = 85
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [swtd_pkg::LEN_W-1:0]  bit_threshold,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [swtd_pkg::LEN_W-1:0]  level_length,
  input  logic                        frame_start,
  output logic                        done_valid,
  input  logic                        done_ready,
  output swtd_pkg::frame_done_t       done
);

  localparam logic [swtd_pkg::IDX_W-1:0] MaxLevelsC = swtd_pkg::IDX_W'(MAX_LEVELS);

  logic [swtd_pkg::IDX_W-1:0]  level_index, level_index_next;
  logic [swtd_pkg::CNT_W-1:0]  bit_count, bit_count_next;
  logic [swtd_pkg::BITS_W-1:0] frame_bits, frame_bits_next;
  logic                        frame_active, frame_active_next;

  logic                        accept;
  logic                        finish;
  logic                        eff_active;
  logic [swtd_pkg::IDX_W-1:0]  eff_index;
  logic [swtd_pkg::CNT_W-1:0]  eff_count;
  logic [swtd_pkg::BITS_W-1:0] eff_bits;
  logic                        take_bit;

  assign in_ready = !done_valid || done_ready;
  assign accept   = in_valid && in_ready;

  // a start level clears the frame before it is looked at
  assign eff_active = frame_start || frame_active;
  assign eff_index  = frame_start ? '0 : level_index;
  assign eff_count  = frame_start ? '0 : bit_count;
  assign eff_bits   = frame_start ? '0 : frame_bits;

  assign take_bit = (eff_index >= swtd_pkg::FIRST_DATA_LEVEL) && !eff_index[0] &&
                    (eff_count < swtd_pkg::FRAME_BITS);

  // next frame state for one level
  always_comb begin
    level_index_next  = level_index;
    bit_count_next    = bit_count;
    frame_bits_next   = frame_bits;
    frame_active_next = frame_active;
    finish            = 1'b0;
    if (accept && eff_active) begin
      level_index_next  = eff_index;
      bit_count_next    = eff_count;
      frame_bits_next   = eff_bits;
      frame_active_next = 1'b1;
      if (level_length == swtd_pkg::TIMEOUT_LEN) begin
        finish            = 1'b1;
        frame_active_next = 1'b0;
      end else begin
        if (take_bit) begin
          frame_bits_next = {eff_bits[swtd_pkg::BITS_W-2:0], level_length > bit_threshold};
          bit_count_next  = eff_count + 1'b1;
        end
        level_index_next = eff_index + 1'b1;
        if (level_index_next >= MaxLevelsC) begin
          finish            = 1'b1;
          frame_active_next = 1'b0;
        end
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      level_index  <= '0;
      bit_count    <= '0;
      frame_bits   <= '0;
      frame_active <= 1'b0;
    end else begin
      level_index  <= level_index_next;
      bit_count    <= bit_count_next;
      frame_bits   <= frame_bits_next;
      frame_active <= frame_active_next;
    end
  end

  // finished frame register
  always_ff @(posedge clk) begin
    if (rst) begin
      done_valid <= 1'b0;
    end else if (in_ready) begin
      done_valid <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      done.bits <= frame_bits_next;
      done.full <= (bit_count_next == swtd_pkg::FRAME_BITS);
    end
  end

`ifndef SYNTHESIS
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    bit_count <= swtd_pkg::FRAME_BITS)
    else $error("bit count beyond a full frame");

  a_index_limit: assert property (@(posedge clk) disable iff (rst)
    frame_active |-> level_index < MaxLevelsC)
    else $error("active frame past its level limit");

  a_finish_closes: assert property (@(posedge clk) disable iff (rst)
    finish |=> done_valid && !frame_active)
    else $error("finished frame not handed on or still active");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    done_valid && !done_ready |=> done_valid && $stable(done))
    else $error("stalled frame record changed");
`endif

endmodule

[src/swtd_calc.sv]
module swtd_calc (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               unit_fahrenheit,
  input  logic                               done_valid,
  output logic                               done_ready,
  input  swtd_pkg::frame_done_t              done,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         status,
  output logic signed [swtd_pkg::TEMP_W-1:0] temperature
);

  logic [7:0]                  b0, b1, b2, b3, b4;
  logic [7:0]                  sum8;
  logic [14:0]                 raw;
  logic [swtd_pkg::Q_W-1:0]    q;
  logic [swtd_pkg::TEMP_W-1:0] mag_c, mag_f, temp_c, temp_f;
  logic [1:0]                  status_next;
  logic [swtd_pkg::TEMP_W-1:0] temp_next;

  assign done_ready = !out_valid || out_ready;

  assign b0 = done.bits[39:32];
  assign b1 = done.bits[31:24];
  assign b2 = done.bits[23:16];
  assign b3 = done.bits[15:8];
  assign b4 = done.bits[7:0];

  assign sum8 = 8'(b0 + b1 + b2 + b3);

  // magnitude in tenths (or whole degrees times ten above the limit)
  assign raw = {b2[6:0], b3};
  assign q   = (raw > swtd_pkg::RAW_LIMIT) ? swtd_pkg::Q_W'(b2) * swtd_pkg::DEG_SCALE
                                           : raw[swtd_pkg::Q_W-1:0];

  // hundredths: celsius is q*10, fahrenheit is q*18 + 3200
  assign mag_c  = swtd_pkg::TEMP_W'(q) * swtd_pkg::C_SCALE;
  assign mag_f  = swtd_pkg::TEMP_W'(q) * swtd_pkg::F_SCALE;
  assign temp_c = b2[7] ? -mag_c : mag_c;
  assign temp_f = (b2[7] ? -mag_f : mag_f) + swtd_pkg::F_OFFSET;

  // status and temperature selection
  always_comb begin
    temp_next = '0;
    if (!done.full) begin
      status_next = swtd_pkg::STATUS_SHORT;
    end else if (b4 != sum8) begin
      status_next = swtd_pkg::STATUS_CHECKSUM;
    end else begin
      status_next = swtd_pkg::STATUS_OK;
      temp_next   = unit_fahrenheit ? temp_f : temp_c;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_ready) begin
      out_valid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ready && done_valid) begin
      status      <= status_next;
      temperature <= temp_next;
    end
  end

`ifndef SYNTHESIS
  a_temp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != swtd_pkg::STATUS_OK |-> temperature == '0)
    else $error("temperature set on a bad frame");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    done_valid && done_ready |=> out_valid)
    else $error("frame record lost before the result register");
`endif

endmodule

[src/single_wire_temp_sensor_decoder.sv]
// channel   dir  payload                              transfer when
// levels    in   level_length[7:0], frame_start       valid && ready
// results   out  status[1:0], temperature[16:0] s     valid && ready
// apb       in   bit_threshold @0x0, unit_fahrenheit @0x4
//
// one level per cycle; ready drops only while a finished frame waits behind a stalled result
// a result passes through the tracker's finished-frame register, then the converter's result register
// the frame tracker updates its level index, bit count and frame bits together for each level
// rst is synchronous: clears frame state, pending results and both registers
module single_wire_temp_sensor_decoder #(
  parameter int MAX_LEVELS = 85
) (
  input  logic                        clk,
  input  logic                        rst,
  swtd_level_if.sink                  levels,
  swtd_result_if.source               results,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swtd_pkg::ADDR_W-1:0] paddr,
  input  logic [swtd_pkg::DATA_W-1:0] pwdata,
  output logic [swtd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  logic [swtd_pkg::LEN_W-1:0] bit_threshold;
  logic                       unit_fahrenheit;
  logic                       done_valid;
  logic                       done_ready;
  swtd_pkg::frame_done_t      done;

  // configuration registers
  swtd_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .bit_threshold   (bit_threshold),
    .unit_fahrenheit (unit_fahrenheit)
  );

  // level tracking and bit capture
  swtd_frame #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_frame (
    .clk           (clk),
    .rst           (rst),
    .bit_threshold (bit_threshold),
    .in_valid      (levels.valid),
    .in_ready      (levels.ready),
    .level_length  (levels.level_length),
    .frame_start   (levels.frame_start),
    .done_valid    (done_valid),
    .done_ready    (done_ready),
    .done          (done)
  );

  // checksum and temperature conversion
  swtd_calc u_calc (
    .clk             (clk),
    .rst             (rst),
    .unit_fahrenheit (unit_fahrenheit),
    .done_valid      (done_valid),
    .done_ready      (done_ready),
    .done            (done),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .status          (results.status),
    .temperature     (results.temperature)
  );

endmodule
